FILE: hdl/salf_pkg.sv
// Shared types and constants for the set-associative tag lookup block.
package salf_pkg;

  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_SET_BITS    = 2'd1,
    REG_WAYS        = 2'd2,
    REG_USE_FIFO    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic show;
  } cmd_t;

  localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
  localparam logic [2:0] SET_BITS_RST    = 3'd0;
  localparam logic [3:0] WAYS_RST        = 4'd8;
  localparam logic       USE_FIFO_RST    = 1'b0;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
  // set_bits above this value saturate to it
  localparam int          SET_BITS_LIMIT = 6;

endpackage

FILE: hdl/salf_ram.sv
// Generic single-port RAM with registered read.
module salf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/salf_ctrl.sv
// Controller state machine sequencing one access at a time.
module salf_ctrl
  import salf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_ready,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a result is shown only after its update
  assert property (@(posedge clk) disable iff (rst) out_valid |-> $past(cmd.update) || $past(out_valid))
    else $error("result without update");
  assert property (@(posedge clk) disable iff (rst) cmd.capture |=> !in_ready)
    else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (rst) cmd.update |=> out_valid)
    else $error("update not followed by result");

endmodule

FILE: hdl/salf_dp.sv
// Datapath: address split, set row RAM, way compare, reorder, counters.
module salf_dp
  import salf_pkg::*;
#(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [31:0]           address,
  input  logic [4:0]            offset_bits,
  input  logic [2:0]            set_bits,
  input  logic [3:0]            ways,
  input  logic                  use_fifo,
  output logic                  hit,
  output logic [5:0]            set_index,
  output logic [31:0]           hit_total,
  output logic [31:0]           miss_total
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int FILL_W = $clog2(MAX_WAYS + 1);
  localparam int POS_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W  = ADDR_WIDTH * MAX_WAYS;
  localparam int RAM_W  = ROW_W + FILL_W;
  localparam int SB_LIM = SET_BITS_LIMIT;

  logic [ADDR_WIDTH-1:0] tag;
  logic [SET_W-1:0]      set_r;
  logic [ROW_W-1:0]      row_q, row_new;
  logic [RAM_W-1:0]      ram_q, ram_new;
  logic [MAX_SETS-1:0]   set_valid;
  logic [FILL_W-1:0]     fill, fill_new, w;
  logic [MAX_WAYS-1:0]   match;
  logic                  hit_c;
  logic [POS_W-1:0]      pos;
  logic [ADDR_WIDTH-1:0] blk;
  logic [2:0]            sb;
  logic [ADDR_WIDTH-1:0] set_full;
  logic [ADDR_WIDTH-1:0] entry [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] shifted [MAX_WAYS];
  logic [FILL_W-1:0]     drop;

  // capture: split the address
  always_comb begin
    sb = (set_bits > 3'(SB_LIM)) ? 3'(SB_LIM) : set_bits;
    blk = ADDR_WIDTH'(address) >> offset_bits;
    set_full = blk & ((ADDR_WIDTH'(1) << sb) - ADDR_WIDTH'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r <= set_full[SET_W-1:0];
      tag   <= blk >> sb;
    end
  end

  // each RAM word holds the set's fill count above its tags
  salf_ram #(.WIDTH(RAM_W), .DEPTH(MAX_SETS)) u_row (
    .clk(clk), .we(cmd.update), .addr(set_r), .wdata(ram_new), .rdata(ram_q)
  );

  assign row_q   = ram_q[ROW_W-1:0];
  assign ram_new = {fill_new, row_new};

  // compare and reorder
  always_comb begin
    fill = set_valid[set_r] ? ram_q[ROW_W +: FILL_W] : '0;
    w = (ways == 4'd0) ? FILL_W'(1) :
        (32'(ways) > MAX_WAYS) ? FILL_W'(MAX_WAYS) : FILL_W'(ways);
    for (int i = 0; i < MAX_WAYS; i++) begin
      entry[i] = row_q[i*ADDR_WIDTH +: ADDR_WIDTH];
      match[i] = (FILL_W'(i) < fill) && (entry[i] == tag);
    end
    hit_c = |match;
    pos = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) pos = POS_W'(i);
    end
    drop = (fill >= w) ? fill - (w - FILL_W'(1)) : '0;
    fill_new = fill;
    for (int i = 0; i < MAX_WAYS; i++) shifted[i] = entry[i];
    if (hit_c) begin
      if (!use_fifo) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (FILL_W'(i) >= FILL_W'(pos) && FILL_W'(i + 1) < fill)
            shifted[i] = entry[i + 1 < MAX_WAYS ? i + 1 : i];
          if (FILL_W'(i + 1) == fill) shifted[i] = tag;
        end
      end
    end else begin
      if (fill >= w) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (32'(i) + 32'(drop) < MAX_WAYS) shifted[i] = entry[32'(i) + 32'(drop)];
        end
        fill_new = w - FILL_W'(1);
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (FILL_W'(i) == fill_new) shifted[i] = tag;
      end
      fill_new = fill_new + FILL_W'(1);
    end
    for (int i = 0; i < MAX_WAYS; i++) row_new[i*ADDR_WIDTH +: ADDR_WIDTH] = shifted[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid  <= '0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (cmd.update) begin
      set_valid[set_r] <= 1'b1;
      if (hit_c) begin
        if (hit_total != COUNT_MAX) hit_total <= hit_total + 32'd1;
      end else if (miss_total != COUNT_MAX) begin
        miss_total <= miss_total + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit       <= hit_c;
      set_index <= 6'(set_r);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.update |-> fill_new <= FILL_W'(MAX_WAYS))
    else $error("fill overflow");

endmodule

FILE: hdl/set_assoc_tag_lookup_lru_fifo_top.sv
// Top level: APB config registers, controller and datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid / in_ready     | address
//  out     | out_valid / out_ready   | hit, set_index, hit_total, miss_total
//  cfg     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// Each word goes through accept, set row read (registered RAM read), compare and
// write back, then the result holds until taken.
// Reset is synchronous; it empties every set and clears both totals.
// An output stall holds the block; no new word is accepted until taken.
module set_assoc_tag_lookup_lru_fifo_top
  import salf_pkg::*;
#(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [5:0]  set_index,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] offset_bits;
  logic [2:0] set_bits;
  logic [3:0] ways;
  logic       use_fifo;
  cmd_t       cmd;
  logic [ADDR_WIDTH-1:0] addr_m;

  assign pready = 1'b1;
  // mask the address to the configured width
  assign addr_m = ADDR_WIDTH'(address);

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      set_bits    <= SET_BITS_RST;
      ways        <= WAYS_RST;
      use_fifo    <= USE_FIFO_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_OFFSET_BITS: offset_bits <= pwdata[4:0];
        REG_SET_BITS:    set_bits    <= pwdata[2:0];
        REG_WAYS:        ways        <= pwdata[3:0];
        REG_USE_FIFO:    use_fifo    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back the selected register
  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[3:2]))
      REG_OFFSET_BITS: prdata = 32'(offset_bits);
      REG_SET_BITS:    prdata = 32'(set_bits);
      REG_WAYS:        prdata = 32'(ways);
      REG_USE_FIFO:    prdata = 32'(use_fifo);
      default:         prdata = '0;
    endcase
  end

  salf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .out_ready, .in_ready, .out_valid, .cmd
  );

  salf_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
    .clk, .rst, .cmd, .address(32'(addr_m)), .offset_bits, .set_bits, .ways, .use_fifo,
    .hit, .set_index, .hit_total, .miss_total
  );

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> $stable(hit_total))
    else $error("total moved under stall");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input and output open together");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ##2 (hit_total + miss_total != $past(hit_total + miss_total, 3)
      || hit_total == COUNT_MAX || miss_total == COUNT_MAX))
    else $error("totals not advanced");

endmodule

FILE: tb/tb.sv
// Testbench for the set-associative tag lookup block with LRU and FIFO replacement.
`timescale 1ns / 100ps

module tb
  import salf_pkg::*;
();

  localparam int NUM_SETS = 64;
  localparam int NUM_WAYS = 8;
  localparam int MAX_CYCLES = 400000;

  // Expected result of one lookup.
  typedef struct {
    logic        hit;
    logic [5:0]  set_index;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } lookup_t;

  // One row of the directed table: an optional register write comes first, then the address.
  // chk says whether the typed-in result is checked on top of the model.
  typedef struct {
    bit          wr_cfg;
    reg_idx_t    reg_sel;
    logic [31:0] reg_val;
    logic [31:0] addr;
    bit          chk;
    logic        hit;
    logic [5:0]  set_index;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [5:0]  set_index;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block's state.
  logic [31:0] shadow_tags [NUM_SETS][NUM_WAYS];
  int unsigned shadow_fill [NUM_SETS];
  logic [31:0] shadow_hits;
  logic [31:0] shadow_misses;
  logic [4:0]  cfg_offset;
  logic [2:0]  cfg_set_bits;
  logic [3:0]  cfg_ways;
  logic        cfg_fifo;

  lookup_t     pending_lookups[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          long_stall = 1'b0;

  always #10 clk = ~clk;

  set_assoc_tag_lookup_lru_fifo_top dut (.*);

  // Count cycles and end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  function automatic void shadow_reset();
    foreach (shadow_fill[s]) shadow_fill[s] = 0;
    shadow_hits = '0;
    shadow_misses = '0;
    cfg_offset = OFFSET_BITS_RST;
    cfg_set_bits = SET_BITS_RST;
    cfg_ways = WAYS_RST;
    cfg_fifo = USE_FIFO_RST;
  endfunction

  function automatic void shadow_config(input reg_idx_t idx, input logic [31:0] val);
    case (idx)
      REG_OFFSET_BITS: cfg_offset = val[4:0];
      REG_SET_BITS:    cfg_set_bits = val[2:0];
      REG_WAYS:        cfg_ways = val[3:0];
      REG_USE_FIFO:    cfg_fifo = val[0];
      default: ;
    endcase
  endfunction

  // Look the address up in the shadow tag store and update it.
  function automatic lookup_t predict_lookup(input logic [31:0] addr);
    lookup_t     res;
    int unsigned sb;
    int unsigned w;
    logic [31:0] blk;
    int unsigned set;
    logic [31:0] tag;
    int unsigned fill;
    int unsigned pos;
    int unsigned drop;
    bit          found;
    sb = (cfg_set_bits > 6) ? 6 : cfg_set_bits;
    w = (cfg_ways == 0) ? 1 : ((cfg_ways > NUM_WAYS) ? NUM_WAYS : cfg_ways);
    blk = addr >> cfg_offset;
    set = blk & ((32'd1 << sb) - 1);
    tag = blk >> sb;
    fill = shadow_fill[set];
    found = 1'b0;
    pos = 0;
    for (int i = 0; i < fill; i++) begin
      if (!found && shadow_tags[set][i] == tag) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      if (shadow_hits != COUNT_MAX) shadow_hits++;
      if (!cfg_fifo) begin
        for (int i = pos; i + 1 < fill; i++) shadow_tags[set][i] = shadow_tags[set][i+1];
        shadow_tags[set][fill-1] = tag;
      end
    end else begin
      if (shadow_misses != COUNT_MAX) shadow_misses++;
      if (fill >= w) begin
        drop = fill - (w - 1);
        for (int i = 0; i + 1 < w; i++) shadow_tags[set][i] = shadow_tags[set][i+drop];
        fill = w - 1;
      end
      shadow_tags[set][fill] = tag;
      fill++;
    end
    shadow_fill[set] = fill;
    res.hit = found;
    res.set_index = set[5:0];
    res.hit_total = shadow_hits;
    res.miss_total = shadow_misses;
    return res;
  endfunction

  // Write one register: setup phase, access phase until pready, then idle.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_config(idx, val);
    @(posedge clk);
  endtask

  // Offer one word and hold it until accepted; queue its expected result.
  task automatic send_word(input logic [31:0] addr);
    in_valid <= 1'b1;
    address <= addr;
    do @(posedge clk); while (!in_ready);
    pending_lookups = {pending_lookups, predict_lookup(addr)};
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    address <= $urandom;
  endtask

  // Wait until every result has come, then let the pipeline drain.
  task automatic drain();
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random address drawn so tags repeat: a small tag pool per set keeps hits frequent.
  function automatic logic [31:0] random_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      a = a & ((32'd1 << (cfg_offset + 6)) - 1);
      a = a | ($urandom_range(0, 11) << (cfg_offset + 6));
      if ($urandom_range(0, 7) == 0) a = a | 32'hFFFF_0000;
    end
    return a;
  endfunction

  // Receiver: stall on its own pattern, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_stall) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0) || (cycle_count % 500 < 100);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, hit}, 32'd0);
      end else begin
        want = pending_lookups[0];
        pending_lookups.delete(0);
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (set_index !== want.set_index)
          report_mismatch("set_index", 32'(set_index), 32'(want.set_index));
        if (hit_total !== want.hit_total) report_mismatch("hit_total", hit_total, want.hit_total);
        if (miss_total !== want.miss_total)
          report_mismatch("miss_total", miss_total, want.miss_total);
      end
    end
  end

  row_t directed[$];

  function automatic void add_row(input bit wr, input reg_idx_t idx, input logic [31:0] val,
                                  input logic [31:0] addr, input bit chk = 1'b0,
                                  input logic h = 1'b0, input logic [5:0] s = 6'd0);
    row_t r;
    r.wr_cfg = wr;
    r.reg_sel = idx;
    r.reg_val = val;
    r.addr = addr;
    r.chk = chk;
    r.hit = h;
    r.set_index = s;
    directed = {directed, r};
  endfunction

  task automatic run_phase(input int count);
    int burst;
    int sent;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_word(random_addr());
        sent++;
      end
      // Keep valid up across a zero gap; always drop it after the last word.
      gap = $urandom_range(0, 6);
      if (gap != 0 || sent >= count) begin
        drop_valid();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    lookup_t exp_first;
    shadow_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset: one set, first access misses, second hits.
    add_row(1'b0, REG_OFFSET_BITS, 0, 32'h0000_0000, 1'b1, 1'b0, 6'd0);
    add_row(1'b0, REG_OFFSET_BITS, 0, 32'h0000_000F, 1'b1, 1'b1, 6'd0);
    add_row(1'b0, REG_OFFSET_BITS, 0, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0);
    add_row(1'b0, REG_OFFSET_BITS, 0, 32'hFFFF_FFF0, 1'b1, 1'b1, 6'd0);
    // Many sets, no offset, one way, FIFO.
    add_row(1'b1, REG_OFFSET_BITS, 0, 32'h0000_003F, 1'b1, 1'b0, 6'd0);
    add_row(1'b1, REG_SET_BITS, 6, 32'h0000_003F, 1'b1, 1'b0, 6'd63);
    add_row(1'b0, REG_SET_BITS, 6, 32'h0000_003F, 1'b1, 1'b1, 6'd63);
    add_row(1'b1, REG_WAYS, 1, 32'h0000_013F, 1'b1, 1'b0, 6'd63);
    add_row(1'b0, REG_WAYS, 1, 32'h0000_003F, 1'b1, 1'b0, 6'd63);
    add_row(1'b1, REG_USE_FIFO, 1, 32'hAAAA_AAAA);
    add_row(1'b0, REG_USE_FIFO, 1, 32'h5555_5555);
    // Too many set bits saturates; ways 0 acts as 1; large offset.
    add_row(1'b1, REG_SET_BITS, 7, 32'h1234_5678);
    add_row(1'b1, REG_WAYS, 0, 32'h1234_5678);
    add_row(1'b0, REG_WAYS, 0, 32'h8765_4321);
    add_row(1'b1, REG_OFFSET_BITS, 31, 32'h8000_0000);
    add_row(1'b0, REG_OFFSET_BITS, 31, 32'h7FFF_FFFF);
    add_row(1'b1, REG_OFFSET_BITS, 16, 32'hFFFF_0000);
    // Ways above the maximum acts as the maximum; lowering ways on a full set.
    add_row(1'b1, REG_WAYS, 15, 32'h0001_0000);
    add_row(1'b1, REG_USE_FIFO, 0, 32'h0002_0000);
    add_row(1'b0, REG_USE_FIFO, 0, 32'h0003_0000);
    add_row(1'b0, REG_USE_FIFO, 0, 32'h0001_0000);
    add_row(1'b1, REG_WAYS, 2, 32'h0002_0000);
    add_row(1'b0, REG_WAYS, 2, 32'h0004_0000);
    add_row(1'b0, REG_WAYS, 2, 32'h0001_0000);

    foreach (directed[k]) begin
      if (directed[k].wr_cfg) begin
        drain();
        write_reg(directed[k].reg_sel, directed[k].reg_val);
      end
      send_word(directed[k].addr);
      drop_valid();
      if (directed[k].chk) begin
        exp_first = pending_lookups[pending_lookups.size()-1];
        if (exp_first.hit !== directed[k].hit || exp_first.set_index !== directed[k].set_index)
          report_mismatch("directed row", 32'(k), 32'(directed[k].hit));
      end
      @(posedge clk);
    end

    // Random phases across several settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_OFFSET_BITS, 4);  write_reg(REG_SET_BITS, 2);
          write_reg(REG_WAYS, 4);         write_reg(REG_USE_FIFO, 0);
        end
        1: begin write_reg(REG_USE_FIFO, 1); write_reg(REG_WAYS, 2); end
        2: begin
          write_reg(REG_OFFSET_BITS, 0);  write_reg(REG_SET_BITS, 0);
          write_reg(REG_WAYS, 8);
        end
        3: begin write_reg(REG_SET_BITS, 6); write_reg(REG_WAYS, 1); end
        4: begin
          write_reg(REG_OFFSET_BITS, 16); write_reg(REG_SET_BITS, 3);
          write_reg(REG_USE_FIFO, 0);     write_reg(REG_WAYS, 3);
        end
        5: begin write_reg(REG_WAYS, 8); write_reg(REG_SET_BITS, 1); end
        6: begin write_reg(REG_WAYS, 5); write_reg(REG_OFFSET_BITS, 7); end
        default: begin write_reg(REG_USE_FIFO, 1); write_reg(REG_SET_BITS, 4); end
      endcase
      // Hold off the receiver for a long stretch while words keep coming.
      if (ph == 2) fork
        begin
          long_stall <= 1'b1;
          repeat (200) @(posedge clk);
          long_stall <= 1'b0;
        end
        run_phase(66);
      join
      else run_phase(66);
      // Pause the sender until everything has come back.
      if (ph == 5) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_lookups.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: set_assoc_tag_lookup_lru_fifo_top.f
hdl/salf_pkg.sv
hdl/salf_ram.sv
hdl/salf_ctrl.sv
hdl/salf_dp.sv
hdl/set_assoc_tag_lookup_lru_fifo_top.sv
tb/tb.sv
